/* rtl/mfs_pkg.sv */
// Shared types and constants for the multilevel feedback queue scheduler.
// No dependencies; imported by every other file of the block.
package mfs_pkg;

  localparam logic FUNC_ENQUEUE  = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;

  localparam int          RUNTIME_W   = 16;
  localparam logic [15:0] RUNTIME_MAX = 16'hFFFF;

  // command word
  typedef struct packed {
    logic        func;
    logic [5:0]  thread_id;
    logic [1:0]  priority_req;
    logic [15:0] burst_length;
  } cmd_t;

  // result word
  typedef struct packed {
    logic        granted;
    logic [5:0]  chosen_thread;
    logic [2:0]  granted_level;
    logic [1:0]  granted_priority;
    logic [15:0] runtime_before;
    logic [7:0]  slice_ticks;
    logic [6:0]  queued_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH,
    ST_COMMIT
  } state_t;

  // occupancy flag update for one list
  typedef struct packed {
    logic set;
    logic clr;
  } occ_cmd_t;

  // per-field write enables of the thread table
  typedef struct packed {
    logic info;
    logic link;
  } tmem_we_t;

  // per-field write enables of the list table
  typedef struct packed {
    logic head;
    logic tail;
  } lmem_we_t;

endpackage

/* rtl/mfs_occupancy.sv */
// List occupancy flags (one per level/priority list) and the search for the
// first non-empty list, lowest level first, then lowest priority. Uses mfs_pkg.
module mfs_occupancy #(
  parameter int LEVELS     = 8,
  parameter int PRIORITIES = 4,
  localparam int LW     = $clog2(LEVELS),
  localparam int PW     = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1,
  localparam int NLISTS = LEVELS * PRIORITIES,
  localparam int LIW    = $clog2(NLISTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  mfs_pkg::occ_cmd_t op,
  input  logic [LIW-1:0]    idx,
  output logic              idx_full,
  output logic              hit,
  output logic [LW-1:0]     first_lvl,
  output logic [PW-1:0]     first_prio,
  output logic [LIW-1:0]    first_idx
);
  import mfs_pkg::*;

  logic [NLISTS-1:0]     nonempty;
  logic [LEVELS-1:0]     lvl_any;
  logic [PRIORITIES-1:0] row;

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else begin
      if (op.set) nonempty[idx] <= 1'b1;
      if (op.clr) nonempty[idx] <= 1'b0;
    end
  end

  assign idx_full = nonempty[idx];

  // two-level pick: first busy level, then first busy priority in that row
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      lvl_any[l] = |nonempty[l*PRIORITIES +: PRIORITIES];
    end
    first_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (lvl_any[l]) first_lvl = LW'(l);
    end
    row = nonempty[first_lvl*PRIORITIES +: PRIORITIES];
    first_prio = '0;
    for (int p = PRIORITIES - 1; p >= 0; p--) begin
      if (row[p]) first_prio = PW'(p);
    end
  end

  assign hit       = |lvl_any;
  assign first_idx = LIW'(first_lvl * PRIORITIES + first_prio);

endmodule

/* rtl/multilevel_feedback_scheduler_top.sv */
// Top level of the multilevel feedback queue scheduler: sequencer, thread
// table and list table memories. Uses mfs_pkg and mfs_occupancy.
//
// One command word is taken when start is high and busy is low; exactly one
// result word follows, shown for one cycle with done, and must be captured
// then. An ignored enqueue or an empty dispatch goes through LOOKUP only, an
// enqueue through LOOKUP and FETCH, and a dispatch through LOOKUP, FETCH and
// COMMIT, before the block is idle again. The states follow the chain of
// memory reads each item walks: thread entry, then list head/tail, then (for
// dispatch) the head thread's entry. The result word appears in the cycle in
// which the next command may already be taken. After reset the thread table
// is cleared one entry per cycle, and busy stays high until it is done.
module multilevel_feedback_scheduler_top #(
  parameter int THREADS    = 64,
  parameter int LEVELS     = 8,
  parameter int PRIORITIES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mfs_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output mfs_pkg::result_t result
);
  import mfs_pkg::*;

  localparam int TW     = $clog2(THREADS);
  localparam int LW     = $clog2(LEVELS);
  localparam int PW     = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
  localparam int NLISTS = LEVELS * PRIORITIES;
  localparam int LIW    = $clog2(NLISTS);
  localparam int CW     = $clog2(THREADS + 1);

  typedef struct packed {
    logic                 waiting;
    logic [LW-1:0]        level;
    logic [RUNTIME_W-1:0] runtime;
    logic [RUNTIME_W-1:0] burst;
  } tinfo_t;

  typedef struct packed {
    tinfo_t        info;
    logic [TW-1:0] link;
  } tent_t;

  typedef struct packed {
    logic [TW-1:0] head;
    logic [TW-1:0] tail;
  } lent_t;

  // memories
  tent_t tmem [THREADS];
  lent_t lmem [NLISTS];

  state_t state, state_next;
  logic [TW-1:0]  clr_addr;
  logic [CW-1:0]  count, count_next;
  logic           done_next;
  result_t        res_next;

  cmd_t           req_q;
  logic [LIW-1:0] li_q;
  logic [LW-1:0]  lvl_q;
  logic [PW-1:0]  prio_q;
  logic [TW-1:0]  t_q;
  logic           last_q;

  tmem_we_t       t_we;
  logic [TW-1:0]  t_waddr, t_raddr, t_wlink;
  tinfo_t         t_winfo;
  tent_t          t_rdata;

  lmem_we_t       l_we;
  logic [LIW-1:0] l_raddr;
  logic [TW-1:0]  l_whead;
  lent_t          l_rdata;

  occ_cmd_t       occ;
  logic           occ_full, occ_hit;
  logic [LW-1:0]  first_lvl;
  logic [PW-1:0]  first_prio;
  logic [LIW-1:0] first_idx;

  logic [TW-1:0]  tid_q;
  logic           tid_valid, demote, enq_go, is_disp;
  tinfo_t         cur;
  logic [LW-1:0]  enq_lvl;
  logic [PW-1:0]  prio_sat;
  logic [LIW-1:0] enq_li;
  logic [16:0]    rt_sum;
  logic [15:0]    rt_new;

  mfs_occupancy #(
    .LEVELS     (LEVELS),
    .PRIORITIES (PRIORITIES)
  ) u_occ (
    .clk        (clk),
    .rst        (rst),
    .op         (occ),
    .idx        (li_q),
    .idx_full   (occ_full),
    .hit        (occ_hit),
    .first_lvl  (first_lvl),
    .first_prio (first_prio),
    .first_idx  (first_idx)
  );

  assign busy = (state != ST_IDLE);

  // enqueue decode: demotion and list index from the thread's stored entry
  assign is_disp   = (req_q.func == FUNC_DISPATCH);
  assign tid_q     = TW'(req_q.thread_id);
  assign tid_valid = (32'(req_q.thread_id) < THREADS);
  assign cur       = t_rdata.info;
  assign demote    = ({1'b0, cur.runtime} >= (17'd1 << cur.level)) &&
                     (cur.level != LW'(LEVELS - 1));
  assign enq_lvl   = demote ? LW'(cur.level + 1'b1) : cur.level;
  assign prio_sat  = (32'(req_q.priority_req) >= PRIORITIES) ? PW'(PRIORITIES - 1)
                                                              : PW'(req_q.priority_req);
  assign enq_li    = LIW'(enq_lvl * PRIORITIES + prio_sat);
  assign enq_go    = tid_valid && !cur.waiting;

  // dispatch runtime update, saturating
  assign rt_sum = {1'b0, t_rdata.info.runtime} + {1'b0, t_rdata.info.burst};
  assign rt_new = rt_sum[16] ? RUNTIME_MAX : rt_sum[15:0];

  // read addresses: the thread entry is read at the accepting edge, the head
  // thread's entry at the end of FETCH
  assign t_raddr = (state == ST_FETCH) ? l_rdata.head : TW'(cmd.thread_id);
  assign l_raddr = is_disp ? first_idx : enq_li;
  assign l_whead = (state == ST_COMMIT) ? t_rdata.link : tid_q;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == TW'(THREADS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_LOOKUP;
      ST_LOOKUP: begin
        if (is_disp) state_next = occ_hit ? ST_FETCH : ST_IDLE;
        else         state_next = enq_go ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH:  state_next = is_disp ? ST_COMMIT : ST_IDLE;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    t_we       = '0;
    t_waddr    = clr_addr;
    t_winfo    = '0;
    t_wlink    = tid_q;
    l_we       = '0;
    occ        = '0;
    count_next = count;
    done_next  = 1'b0;
    res_next   = '0;
    res_next.queued_count = 7'(count);
    unique case (state)
      ST_CLEAR: begin
        t_we.info = 1'b1;
      end
      ST_IDLE: begin
      end
      ST_LOOKUP: begin
        if (!is_disp && enq_go) begin
          t_we.info       = 1'b1;
          t_waddr         = tid_q;
          t_winfo.waiting = 1'b1;
          t_winfo.level   = enq_lvl;
          t_winfo.runtime = demote ? '0 : cur.runtime;
          t_winfo.burst   = req_q.burst_length;
        end
        // ignored enqueue or nothing to dispatch: answer right away
        if ((is_disp && !occ_hit) || (!is_disp && !enq_go)) done_next = 1'b1;
      end
      ST_FETCH: begin
        if (!is_disp) begin
          if (occ_full) begin
            t_we.link = 1'b1;
            t_waddr   = l_rdata.tail;
          end
          l_we.tail  = 1'b1;
          l_we.head  = !occ_full;
          occ.set    = 1'b1;
          count_next = CW'(count + 1'b1);
          done_next  = 1'b1;
          res_next.queued_count = 7'(count_next);
        end
      end
      ST_COMMIT: begin
        t_we.info       = 1'b1;
        t_waddr         = t_q;
        t_winfo.waiting = 1'b0;
        t_winfo.level   = t_rdata.info.level;
        t_winfo.runtime = rt_new;
        t_winfo.burst   = t_rdata.info.burst;
        if (last_q) occ.clr   = 1'b1;
        else        l_we.head = 1'b1;
        count_next = (count != '0) ? CW'(count - 1'b1) : count;
        done_next  = 1'b1;
        res_next.granted          = 1'b1;
        res_next.chosen_thread    = 6'(t_q);
        res_next.granted_level    = 3'(lvl_q);
        res_next.granted_priority = 2'(prio_q);
        res_next.runtime_before   = t_rdata.info.runtime;
        res_next.slice_ticks      = 8'(16'd1 << lvl_q);
        res_next.queued_count     = 7'(count_next);
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= TW'(clr_addr + 1'b1);
      count <= count_next;
      done  <= done_next;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (start && !busy) req_q <= cmd;
    if (state == ST_LOOKUP) begin
      li_q   <= l_raddr;
      lvl_q  <= is_disp ? first_lvl : enq_lvl;
      prio_q <= is_disp ? first_prio : prio_sat;
    end
    if (state == ST_FETCH) begin
      t_q    <= l_rdata.head;
      last_q <= (l_rdata.tail == l_rdata.head);
    end
    result <= res_next;
  end

  // Thread table. Items run one at a time and every write lands before the
  // next item's first read, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (t_we.info) tmem[t_waddr].info <= t_winfo;
    if (t_we.link) tmem[t_waddr].link <= t_wlink;
    t_rdata <= tmem[t_raddr];
  end

  // list head/tail table; entries only used while the occupancy flag is set
  always_ff @(posedge clk) begin
    if (l_we.head) lmem[li_q].head <= l_whead;
    if (l_we.tail) lmem[li_q].tail <= tid_q;
    l_rdata <= lmem[l_raddr];
  end

endmodule

/* rtl/mfs_checker.sv */
// Port-level checks for the multilevel feedback queue scheduler top level,
// attached by bind. Uses mfs_pkg.
module mfs_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input mfs_pkg::result_t result
);
  import mfs_pkg::*;

  // a taken command always occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after a command word was taken");

  // a result word only closes a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result word outside the end of a busy period");

  // words without a grant carry only the queue count
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    done && !result.granted |-> result.chosen_thread == 6'd0 &&
      result.granted_level == 3'd0 && result.granted_priority == 2'd0 &&
      result.runtime_before == 16'd0 && result.slice_ticks == 8'd0)
    else $error("non-granted result word has stray fields");

  // a slice is a single power of two, or zero once it passes 8 bits
  a_slice_shape: assert property (@(posedge clk) disable iff (rst)
    done && result.granted |-> $onehot0(result.slice_ticks))
    else $error("slice is not a power of two");

  // a grant never leaves the queue count at the 7-bit maximum
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    done && result.granted |-> result.queued_count != 7'd127)
    else $error("queue count out of range after a grant");

endmodule

bind multilevel_feedback_scheduler_top mfs_checker u_mfs_checker (.*);

/* dv/mfs_checker.sv */
// Scoreboard for the multilevel feedback queue scheduler: watches the command
// and result channels, predicts each result word and compares it.
// Depends on mfs_pkg for the command and result word types.
module mfs_scoreboard
  import mfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    done,
  input  result_t result,
  output int      mismatches,
  output int      outstanding
);

  localparam int THREADS    = 64;
  localparam int LEVELS     = 8;
  localparam int PRIORITIES = 4;
  localparam int NLISTS     = LEVELS * PRIORITIES;

  // shadow of the scheduler state
  logic [2:0]  level_tbl   [THREADS];
  logic [15:0] runtime_tbl [THREADS];
  logic [15:0] burst_tbl   [THREADS];
  logic [5:0]  link_tbl    [THREADS];
  logic        waiting     [THREADS];
  logic [5:0]  head_tbl    [NLISTS];
  logic [5:0]  tail_tbl    [NLISTS];
  logic        occupied    [NLISTS];
  logic [6:0]  waiting_total;

  result_t awaited_results [$];

  initial mismatches = 0;
  initial outstanding = 0;

  function automatic result_t schedule_step(cmd_t c);
    result_t     r;
    int unsigned li;
    int unsigned lvl;
    logic [5:0]  t;
    logic [16:0] sum;
    bit          found;
    r = '0;
    if (c.func == FUNC_ENQUEUE) begin
      t = c.thread_id;
      if (!waiting[t]) begin
        lvl = level_tbl[t];
        // demote once the slice of the current level is used up
        if (int'(runtime_tbl[t]) >= (1 << lvl) && lvl != LEVELS - 1) begin
          lvl++;
          runtime_tbl[t] = '0;
        end
        level_tbl[t] = lvl[2:0];
        burst_tbl[t] = c.burst_length;
        li = lvl * PRIORITIES + c.priority_req;
        if (occupied[li]) link_tbl[tail_tbl[li]] = t;
        else head_tbl[li] = t;
        tail_tbl[li]  = t;
        occupied[li]  = 1'b1;
        waiting[t]    = 1'b1;
        waiting_total = waiting_total + 7'd1;
      end
    end else begin
      found = 1'b0;
      for (li = 0; li < NLISTS && !found; li++) begin
        if (occupied[li]) begin
          found = 1'b1;
          t = head_tbl[li];
          lvl = li / PRIORITIES;
          if (tail_tbl[li] == t) occupied[li] = 1'b0;
          else head_tbl[li] = link_tbl[t];
          waiting[t] = 1'b0;
          if (waiting_total != 0) waiting_total = waiting_total - 7'd1;
          r.granted          = 1'b1;
          r.chosen_thread    = t;
          r.granted_level    = lvl[2:0];
          r.granted_priority = 2'(li % PRIORITIES);
          r.runtime_before   = runtime_tbl[t];
          r.slice_ticks      = 8'(1 << lvl);
          sum = {1'b0, runtime_tbl[t]} + {1'b0, burst_tbl[t]};
          runtime_tbl[t] = sum[16] ? RUNTIME_MAX : sum[15:0];
        end
      end
    end
    r.queued_count = waiting_total;
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        level_tbl[i]   = '0;
        runtime_tbl[i] = '0;
        burst_tbl[i]   = '0;
        link_tbl[i]    = '0;
        waiting[i]     = 1'b0;
      end
      for (int i = 0; i < NLISTS; i++) begin
        head_tbl[i] = '0;
        tail_tbl[i] = '0;
        occupied[i] = 1'b0;
      end
      waiting_total = '0;
      awaited_results.delete();
    end else begin
      // a result word always belongs to an earlier command, so pop first
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no command outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("granted", want.granted, result.granted);
          compare_field("chosen_thread", want.chosen_thread, result.chosen_thread);
          compare_field("granted_level", want.granted_level, result.granted_level);
          compare_field("granted_priority", want.granted_priority,
                        result.granted_priority);
          compare_field("runtime_before", want.runtime_before, result.runtime_before);
          compare_field("slice_ticks", want.slice_ticks, result.slice_ticks);
          compare_field("queued_count", want.queued_count, result.queued_count);
        end
      end
      if (start && !busy) awaited_results.push_back(schedule_step(cmd));
    end
    outstanding <= awaited_results.size();
  end

endmodule

/* dv/tb.sv */
// Testbench top for the multilevel feedback queue scheduler: clock, reset,
// command stimulus, watchdog and verdict. Uses mfs_pkg, mfs_scoreboard and the block.
module tb;
  import mfs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1475;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  logic    done;
  cmd_t    cmd;
  result_t result;
  int      mismatches;
  int      outstanding;
  int      idle_cycles = 0;
  bit      no_gaps = 1'b0;

  multilevel_feedback_scheduler_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  mfs_scoreboard u_chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // no command or result word moving for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cmd_t command(logic f, logic [5:0] tid, logic [1:0] prio,
                                   logic [15:0] burst);
    cmd_t c;
    c.func         = f;
    c.thread_id    = tid;
    c.priority_req = prio;
    c.burst_length = burst;
    return c;
  endfunction

  task automatic issue(input cmd_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic enqueue(input logic [5:0] tid, input logic [1:0] prio,
                         input logic [15:0] burst);
    issue(command(FUNC_ENQUEUE, tid, prio, burst));
  endtask

  // fields other than func are don't-care on dispatch
  task automatic dispatch();
    issue(command(FUNC_DISPATCH, 6'($urandom), 2'($urandom), 16'($urandom)));
  endtask

  function automatic logic [15:0] pick_burst();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 15));
      1: return 16'($urandom_range(0, 300));
      2: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  initial begin
    int fill_bias;
    int pool;
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty dispatch, FIFO order, duplicate enqueue, extremes
    dispatch();
    enqueue(6'd0, 2'd0, 16'h0000);
    enqueue(6'd1, 2'd0, 16'h0003);
    enqueue(6'd63, 2'd3, 16'hFFFF);
    enqueue(6'd63, 2'd1, 16'h1234);
    repeat (4) dispatch();
    // walk one thread down every level, then saturate its runtime on the last
    for (int k = 0; k < 8; k++) begin
      enqueue(6'd63, 2'(k), 16'hFFFF);
      dispatch();
    end

    fill_bias = 50;
    pool = 63;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        fill_bias = $urandom_range(20, 85);
        no_gaps   = ($urandom_range(0, 3) == 0);
        pool      = ($urandom_range(0, 2) == 0) ? 7 : 63;
      end
      if ($urandom_range(0, 99) < fill_bias)
        enqueue(6'($urandom_range(0, pool)), 2'($urandom), pick_burst());
      else
        dispatch();
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
